// File: rtl/core/kfm_pkg.sv
// ----------------------------------------------------------------------------
// kfm_pkg
// shared types, constants and frame template for the keepalive frame matcher
// ----------------------------------------------------------------------------
`default_nettype none

package kfm_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned POS_W       = 5;
    localparam int unsigned IDX_W       = 4;
    localparam int unsigned TPL_LEN     = 16;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'h7E;
    localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'h7D;
    localparam logic [BYTE_W-1:0] ESC_XOR    = 8'h20;
    localparam logic [BYTE_W:0]   SUM_TARGET = 9'h0FF;

    localparam logic [IDX_W-1:0] FIRST_SUMMED = 4'd3;
    localparam logic [IDX_W-1:0] FIRST_DC     = 4'd4;
    localparam logic [IDX_W-1:0] LAST_DC      = 4'd13;

    // classified byte handed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              clr;
        logic              hold;
    } kfm_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } kfm_qstat_t;

    function automatic logic [BYTE_W-1:0] tpl_value(input logic [IDX_W-1:0] idx);
        logic [BYTE_W-1:0] v;
        unique case (idx)
            4'd0:    v = START_BYTE;
            4'd1:    v = 8'h00;
            4'd2:    v = 8'h0D;
            4'd3:    v = 8'h80;
            4'd14:   v = 8'h01;
            4'd15:   v = 8'h02;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic tpl_care(input logic [IDX_W-1:0] idx);
        return (idx < FIRST_DC) || (idx > LAST_DC);
    endfunction

    function automatic logic tpl_summed(input logic [IDX_W-1:0] idx);
        return idx >= FIRST_SUMMED;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/kfm_front.sv
// ----------------------------------------------------------------------------
// kfm_front
// accepts raw bytes, undoes the link escaping and flags start bytes
// ----------------------------------------------------------------------------
`default_nettype none

module kfm_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [kfm_pkg::BYTE_W-1:0]    s_axis_tdata,
    input  wire kfm_pkg::kfm_qstat_t           qstat,
    output logic                               push,
    output kfm_pkg::kfm_item_t                 item
);

    logic esc_reg;
    logic esc_next;
    logic is_start;
    logic esc_eff;

    assign s_axis_tready = !qstat.full;
    assign push          = s_axis_tvalid && !qstat.full;
    assign is_start      = (s_axis_tdata == kfm_pkg::START_BYTE);
    assign esc_eff       = esc_reg && !is_start;

    always_comb
    begin
        item.clr  = is_start;
        item.hold = 1'b0;
        item.data = s_axis_tdata;
        esc_next  = 1'b0;
        if (esc_eff)
        begin
            item.data = s_axis_tdata ^ kfm_pkg::ESC_XOR;
        end
        else if (s_axis_tdata == kfm_pkg::ESC_BYTE)
        begin
            item.hold = 1'b1;
            esc_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg <= 1'b0;
        end
        else if (push)
        begin
            esc_reg <= esc_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/kfm_queue.sv
// ----------------------------------------------------------------------------
// kfm_queue
// short fifo of classified bytes between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module kfm_queue #(
    parameter int unsigned DEPTH = kfm_pkg::QUEUE_DEPTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire kfm_pkg::kfm_item_t   wr_item,
    input  wire logic                 pop,
    output kfm_pkg::kfm_item_t        rd_item,
    output kfm_pkg::kfm_qstat_t       qstat
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    kfm_pkg::kfm_item_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign qstat.full  = (count_reg == FULL_CNT);
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign rd_item     = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/kfm_back.sv
// ----------------------------------------------------------------------------
// kfm_back
// template matcher with running checksum and registered result stage
// ----------------------------------------------------------------------------
`default_nettype none

module kfm_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire kfm_pkg::kfm_item_t   item,
    input  wire kfm_pkg::kfm_qstat_t  qstat,
    output logic                      pop,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [7:0]                m_axis_tdata
);

    logic [kfm_pkg::POS_W-1:0]  pos_reg;
    logic [kfm_pkg::POS_W-1:0]  pos_next;
    logic [kfm_pkg::BYTE_W-1:0] sum_reg;
    logic [kfm_pkg::BYTE_W-1:0] sum_next;
    logic [kfm_pkg::BYTE_W-1:0] sum_base;
    logic [kfm_pkg::IDX_W-1:0]  idx;
    logic                       alive_next;
    logic                       out_valid_reg;
    logic                       out_alive_reg;
    logic [kfm_pkg::POS_W-1:0]  out_pos_reg;

    assign pop      = !qstat.empty && (!out_valid_reg || m_axis_tready);
    assign idx      = pos_reg[kfm_pkg::IDX_W-1:0];
    assign sum_base = item.clr ? '0 : sum_reg;

    always_comb
    begin
        pos_next   = pos_reg;
        sum_next   = sum_base;
        alive_next = 1'b0;
        if (!item.hold)
        begin
            if (pos_reg[kfm_pkg::POS_W-1])
            begin
                // checksum byte
                alive_next = ({1'b0, sum_base} + {1'b0, item.data}) == kfm_pkg::SUM_TARGET;
                pos_next   = '0;
            end
            else
            begin
                if (kfm_pkg::tpl_summed(idx))
                begin
                    sum_next = sum_base + item.data;
                end
                if (kfm_pkg::tpl_care(idx) && (kfm_pkg::tpl_value(idx) != item.data))
                begin
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                pos_reg       <= pos_next;
                sum_reg       <= sum_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_alive_reg <= alive_next;
            out_pos_reg   <= pos_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_pos_reg, out_alive_reg};

endmodule

`default_nettype wire

// File: rtl/core/keepalive_frame_matcher_core.sv
// ----------------------------------------------------------------------------
// keepalive_frame_matcher_core
// matches received link bytes against the keepalive frame template
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one raw received byte per request in tdata.
//   m_axis returns one result per input byte: alive in bit 0, the template
//   position after the byte in bits 5:1 (16 = checksum byte awaited).
//   a byte accepted on s_axis is escape-decoded combinationally, written
//   into a queue slot, then popped into the matcher result register.
//   throughput: one byte per cycle while m_axis is not stalled; the back
//   stage updates position and checksum as each byte is popped.
//   a receiver stall holds the result register; the queue between the
//   escape decoder and the matcher absorbs QUEUE_DEPTH bytes before
//   s_axis_tready drops.
//   reset clears the escape flag, position, checksum, queue and result
//   valid flag; the block takes bytes as soon as reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module keepalive_frame_matcher_core #(
    parameter int unsigned QUEUE_DEPTH = kfm_pkg::QUEUE_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // rx_data[7:0]
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata    // alive[0], match_position[5:1], zero[7:6]
);

    kfm_pkg::kfm_item_t  fe_item;
    kfm_pkg::kfm_item_t  be_item;
    kfm_pkg::kfm_qstat_t qstat;
    logic                fe_push;
    logic                be_pop;

    kfm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .qstat         (qstat),
        .push          (fe_push),
        .item          (fe_item)
    );

    kfm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fe_push),
        .wr_item (fe_item),
        .pop     (be_pop),
        .rd_item (be_item),
        .qstat   (qstat)
    );

    kfm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (be_item),
        .qstat         (qstat),
        .pop           (be_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        !(fe_push && qstat.full))
        else $error("push into full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(be_pop && qstat.empty))
        else $error("pop from empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[5:1] == 5'd0))
        else $error("alive without return to start position");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[5:1] <= 5'd16))
        else $error("template position out of range");

endmodule

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for keepalive_frame_matcher_core: raw link bytes go in
// on s_axis, and every result on m_axis is checked against a cycle-free model
// of the template matcher (position, checksum, escape flag). stimulus is a
// short directed run, then mostly escaped keepalive frames with random
// content, mixed with noise, corrupted and cut-off frames, under two
// patterns of sender and receiver stalls and one phase with no stalls
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] FRAME_LEN_HI   = 8'h00;
    localparam logic [7:0] FRAME_LEN_LO   = 8'h0D;
    localparam logic [7:0] API_KEEPALIVE  = 8'h80;
    localparam logic [7:0] PAYLOAD_FIRST  = 8'h01;
    localparam logic [7:0] PAYLOAD_SECOND = 8'h02;
    localparam int         TOTAL_BYTES    = 1100;
    localparam int         CYCLE_LIMIT    = 200000;
    localparam int         DIRECTED_LEN   = 24;

    // start after a lone escape, a frame carrying an escaped start byte,
    // a start byte in mid-frame, then two escape bytes in a row
    localparam logic [7:0] DIRECTED [DIRECTED_LEN] = '{
        8'h7D, 8'h7E, 8'h00, 8'h0D, 8'h80, 8'h7D, 8'h5E, 8'hFF,
        8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'hAA, 8'h00,
        8'h01, 8'h02, 8'h56, 8'h7E, 8'h00, 8'h7E, 8'h7D, 8'h7D
    };

    typedef struct {
        logic                      alive;
        logic [kfm_pkg::POS_W-1:0] position;
    } match_result_t;

    class frame_match_tracker;
        match_result_t             awaited_results[$];
        logic [kfm_pkg::POS_W-1:0] tpl_pos;
        logic [7:0]                checksum;
        logic                      escape_seen;

        function new();
            tpl_pos     = '0;
            checksum    = '0;
            escape_seen = 1'b0;
        endfunction

        function void note_rx_byte(input logic [7:0] raw);
            logic [7:0]    b;
            logic          breaks;
            match_result_t r;
            b       = raw;
            r.alive = 1'b0;
            if (b == kfm_pkg::START_BYTE)
            begin
                escape_seen = 1'b0;
                checksum    = '0;
            end
            if (escape_seen)
            begin
                b           = b ^ kfm_pkg::ESC_XOR;
                escape_seen = 1'b0;
            end
            else if (b == kfm_pkg::ESC_BYTE)
            begin
                escape_seen = 1'b1;
                r.position  = tpl_pos;
                awaited_results.push_back(r);
                return;
            end
            if (tpl_pos >= kfm_pkg::TPL_LEN)
            begin
                r.alive = (({1'b0, checksum} + {1'b0, b}) == kfm_pkg::SUM_TARGET);
                tpl_pos = '0;
            end
            else
            begin
                if (tpl_pos >= kfm_pkg::FIRST_SUMMED)
                    checksum = checksum + b;
                case (tpl_pos)
                    5'd0:    breaks = (b != kfm_pkg::START_BYTE);
                    5'd1:    breaks = (b != FRAME_LEN_HI);
                    5'd2:    breaks = (b != FRAME_LEN_LO);
                    5'd3:    breaks = (b != API_KEEPALIVE);
                    5'd14:   breaks = (b != PAYLOAD_FIRST);
                    5'd15:   breaks = (b != PAYLOAD_SECOND);
                    default: breaks = 1'b0;
                endcase
                tpl_pos = breaks ? '0 : tpl_pos + 1'b1;
            end
            r.position = tpl_pos;
            awaited_results.push_back(r);
        endfunction

        function bit check_match_result(input logic [7:0] tdata, output string diff);
            match_result_t want;
            bit            ok;
            want = awaited_results.pop_front();
            ok   = 1'b1;
            diff = "";
            if (tdata[0] !== want.alive)
            begin
                ok   = 1'b0;
                diff = {diff, $sformatf(" alive %b want %b", tdata[0], want.alive)};
            end
            if (tdata[5:1] !== want.position)
            begin
                ok   = 1'b0;
                diff = {diff, $sformatf(" position %0d want %0d", tdata[5:1], want.position)};
            end
            if (tdata[7:6] !== 2'b00)
            begin
                ok   = 1'b0;
                diff = {diff, $sformatf(" pad bits %b", tdata[7:6])};
            end
            return ok;
        endfunction
    endclass

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = '0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;

    frame_match_tracker tracker;
    logic [7:0]         tx_bytes[$];
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int                 bytes_sent    = 0;
    int                 errors        = 0;
    int                 cycle_count   = 0;

    keepalive_frame_matcher_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report(input string msg);
        $display("mismatch:%s", msg);
        errors++;
    endtask

    always @(posedge clk)
    begin : result_monitor
        string diff;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (tracker.awaited_results.size() == 0)
                report($sformatf(" result 0x%02h with nothing awaited", m_axis_tdata));
            else if (!tracker.check_match_result(m_axis_tdata, diff))
                report(diff);
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(11))
            0:       return kfm_pkg::START_BYTE;
            1:       return kfm_pkg::ESC_BYTE;
            2:       return 8'h00;
            3:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tracker.note_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic queue_frame();
        logic [7:0] body[$];
        logic [7:0] sum;
        int         cut;
        body = '{FRAME_LEN_HI, FRAME_LEN_LO, API_KEEPALIVE};
        repeat (10)
            body.push_back(rand_byte());
        body.push_back(PAYLOAD_FIRST);
        body.push_back(PAYLOAD_SECOND);
        sum = '0;
        for (int i = 2; i < body.size(); i++)
            sum = sum + body[i];
        body.push_back(kfm_pkg::SUM_TARGET[7:0] - sum);
        case ($urandom_range(15))
            0:       body[$urandom_range(body.size() - 1)] = rand_byte();
            1:       body[body.size() - 1] = rand_byte();
            2:
            begin
                cut = $urandom_range(body.size() - 1);
                while (body.size() > cut)
                    void'(body.pop_back());
            end
            default: ;
        endcase
        tx_bytes.push_back(kfm_pkg::START_BYTE);
        foreach (body[i])
        begin
            if (body[i] == kfm_pkg::START_BYTE || body[i] == kfm_pkg::ESC_BYTE ||
                (body[i] != (kfm_pkg::START_BYTE ^ kfm_pkg::ESC_XOR) &&
                 $urandom_range(19) == 0))
            begin
                tx_bytes.push_back(kfm_pkg::ESC_BYTE);
                tx_bytes.push_back(body[i] ^ kfm_pkg::ESC_XOR);
            end
            else
                tx_bytes.push_back(body[i]);
        end
        // raw start byte dropped somewhere into the frame
        if ($urandom_range(15) == 0)
            tx_bytes.insert($urandom_range(1, tx_bytes.size() - 1), kfm_pkg::START_BYTE);
    endtask

    initial
    begin
        tracker = new();
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 27;
                    recv_idle_pct = 57;
                end
                1:
                begin
                    send_idle_pct = 57;
                    recv_idle_pct = 27;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (ph == 0)
                foreach (DIRECTED[i])
                    send_byte(DIRECTED[i]);
            while (bytes_sent < TOTAL_BYTES * (ph + 1) / 3)
            begin
                if ($urandom_range(9) < 7)
                    queue_frame();
                else
                    repeat ($urandom_range(1, 4))
                        tx_bytes.push_back(rand_byte());
                while (tx_bytes.size() != 0)
                    send_byte(tx_bytes.pop_front());
            end
        end
        s_axis_tvalid <= 1'b0;
        while (tracker.awaited_results.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
